// ===== rtl/core/sem_pkg.sv =====
// Shared types, constants and sequencer states for the Sobel edge magnitude block.
`timescale 1ns / 1ps
package sem_pkg;

   localparam int unsigned MaxWidth    = 4096;
   localparam int unsigned HeightLimit = 4096;
   localparam int unsigned ColBits     = 12;
   localparam int unsigned GeomBits    = 13;
   localparam int unsigned AddrBits    = 3;

   // Register map (byte addresses 4*i)
   localparam logic RegImageWidth  = 1'b0;
   localparam logic RegImageHeight = 1'b1;

   localparam logic [GeomBits-1:0] WidthReset  = 13'd640;
   localparam logic [GeomBits-1:0] HeightReset = 13'd480;
   localparam logic [GeomBits-1:0] GeomMin     = 13'd3;
   localparam logic [GeomBits-1:0] WidthMax    = 13'd4096;
   localparam logic [GeomBits-1:0] HeightMax   = 13'd4096;

   // floor(x/9) = (x * ceil(2^25/9)) >> 25 for any x below 2^21
   localparam int unsigned         SumBits   = 21;
   localparam int unsigned         RecipBits = 22;
   localparam int unsigned         RecipShift = 25;
   localparam logic [RecipBits-1:0] RecipNine = 22'd3728271;

   localparam int unsigned RootBits = 38;
   localparam int unsigned MagBits  = 19;

   typedef logic [23:0]      pix_type;
   typedef pix_type [8:0]    nbhd_type;   // index row*3 + col
   typedef logic [ColBits-1:0] pos_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_READ,
      TOP_CALC,
      TOP_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      MAG_IDLE,
      MAG_GRAD,
      MAG_SQR,
      MAG_ROOT,
      MAG_ACC,
      MAG_MUL,
      MAG_FIN
   } mag_state_type;

   typedef struct packed {
      logic start;
   } mag_ctl_type;

   typedef struct packed {
      logic       done;
      logic [7:0] gray;
   } mag_sts_type;

   function automatic logic [7:0] chan(input pix_type px, input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = px[7:0];
         2'd1:    b = px[15:8];
         2'd2:    b = px[23:16];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/core/sem_ifs.sv =====
// Valid/ready channel interfaces for pixel input and edge result output.
`timescale 1ns / 1ps
interface sem_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface sem_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  edge_gray;
   logic [11:0] center_col;
   logic [11:0] center_row;
   logic        frame_last;
   modport source (output valid, output edge_gray, output center_col, output center_row,
                   output frame_last, input ready);
   modport sink   (input valid, input edge_gray, input center_col, input center_row,
                   input frame_last, output ready);
endinterface

// ===== rtl/core/sem_mag.sv =====
// Sequential gradient, bit-serial square root and divide-by-nine unit.
`timescale 1ns / 1ps
module sem_mag (
   input  logic                clock,
   input  logic                reset,
   input  sem_pkg::mag_ctl_type ctl,
   input  sem_pkg::nbhd_type   nbhd,
   output sem_pkg::mag_sts_type sts
);

   sem_pkg::mag_state_type state_ff, state_in;
   logic [1:0]                         ch_ff, ch_in;
   logic signed [11:0]                 gx_ff, gx_in, gy_ff, gy_in;
   logic [sem_pkg::RootBits-1:0]       v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [sem_pkg::SumBits-1:0]        sum_ff, sum_in;
   logic [sem_pkg::SumBits+sem_pkg::RecipBits-1:0] prod_ff, prod_in;

   logic [7:0]  b [9];
   logic [9:0]  s_top, s_bot, s_lft, s_rgt;
   logic [9:0]  ax, ay;
   logic [sem_pkg::SumBits-1:0] sq;
   logic [sem_pkg::RootBits-1:0] trial;
   logic [9:0]  quot;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         b[i] = sem_pkg::chan(nbhd[i], ch_ff);
      end
   end

   assign s_top = {2'b0, b[0]} + {1'b0, b[1], 1'b0} + {2'b0, b[2]};
   assign s_bot = {2'b0, b[6]} + {1'b0, b[7], 1'b0} + {2'b0, b[8]};
   assign s_lft = {2'b0, b[0]} + {1'b0, b[3], 1'b0} + {2'b0, b[6]};
   assign s_rgt = {2'b0, b[2]} + {1'b0, b[5], 1'b0} + {2'b0, b[8]};

   assign ax = gx_ff[11] ? 10'(-gx_ff) : gx_ff[9:0];
   assign ay = gy_ff[11] ? 10'(-gy_ff) : gy_ff[9:0];
   assign sq = {1'b0, {10'd0, ax} * {10'd0, ax}} + {1'b0, {10'd0, ay} * {10'd0, ay}};
   assign trial = res_ff + bit_ff;

   assign quot = prod_ff[sem_pkg::SumBits+sem_pkg::RecipBits-1:sem_pkg::RecipShift+8];
   assign sts.gray = (quot > 10'd255) ? 8'd255 : quot[7:0];
   assign sts.done = (state_ff == sem_pkg::MAG_FIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::MAG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ch_ff   <= ch_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      case (state_ff)
         sem_pkg::MAG_IDLE: begin
            if (ctl.start) begin
               ch_in    = 2'd0;
               sum_in   = '0;
               state_in = sem_pkg::MAG_GRAD;
            end
         end
         sem_pkg::MAG_GRAD: begin
            gx_in    = $signed({2'b0, s_bot}) - $signed({2'b0, s_top});
            gy_in    = $signed({2'b0, s_rgt}) - $signed({2'b0, s_lft});
            state_in = sem_pkg::MAG_SQR;
         end
         sem_pkg::MAG_SQR: begin
            v_in     = {1'b0, sq, 16'd0};
            res_in   = '0;
            bit_in   = sem_pkg::RootBits'(1) << 36;
            state_in = sem_pkg::MAG_ROOT;
         end
         sem_pkg::MAG_ROOT: begin
            // one result bit a cycle
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = sem_pkg::MAG_ACC;
            end
         end
         sem_pkg::MAG_ACC: begin
            sum_in = sum_ff + {2'b0, res_ff[sem_pkg::MagBits-1:0]};
            if (ch_ff == 2'd2) begin
               state_in = sem_pkg::MAG_MUL;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = sem_pkg::MAG_GRAD;
            end
         end
         sem_pkg::MAG_MUL: begin
            prod_in  = sum_ff * sem_pkg::RecipNine;
            state_in = sem_pkg::MAG_FIN;
         end
         sem_pkg::MAG_FIN: begin
            state_in = sem_pkg::MAG_IDLE;
         end
         default: begin
            state_in = sem_pkg::MAG_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/sobel_edge_magnitude_rgb.sv =====
// Top level: Sobel edge magnitude over an RGB raster pixel stream.
`timescale 1ns / 1ps
// Channel   Dir  Beat
// req_bus   in   one pixel: blue, green, red
// rsp_bus   out  one interior result: edge_gray, center_col, center_row, frame_last
// csr_*     in   APB writes/reads of image_width (0x0), image_height (0x4)
//
// One pixel at a time. A border pixel goes from beat to next beat through the line read and
// back to idle. An interior pixel goes through the line read, sem_mag (3 channels
// of gradient, square and a 19-step bit-serial square root, then the divide-by-nine
// multiply), emit and idle.
// Reset clears counters, window and handshakes; line memory contents are left as is.
// A result waiting in the output register does not stall the next pixel's work,
// only its own emit step.
module sobel_edge_magnitude_rgb (
   input  logic                          clock,
   input  logic                          reset,
   sem_req_if.sink                       req_bus,
   sem_rsp_if.source                     rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sem_pkg::AddrBits-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   // ---- configuration registers ----
   logic [sem_pkg::GeomBits-1:0] width_ff, height_ff;
   logic                         csr_wr;
   logic [sem_pkg::GeomBits-1:0] w_use, h_use;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == sem_pkg::RegImageHeight)
                       ? {19'd0, height_ff} : {19'd0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::WidthReset;
         height_ff <= sem_pkg::HeightReset;
      end else if (csr_wr) begin
         if (csr_paddr[2] == sem_pkg::RegImageHeight) begin
            height_ff <= csr_pwdata[sem_pkg::GeomBits-1:0];
         end else begin
            width_ff <= csr_pwdata[sem_pkg::GeomBits-1:0];
         end
      end
   end

   // geometry in use, clamped to [3, max]
   assign w_use = (width_ff < sem_pkg::GeomMin) ? sem_pkg::GeomMin :
                  (width_ff > sem_pkg::WidthMax) ? sem_pkg::WidthMax : width_ff;
   assign h_use = (height_ff < sem_pkg::GeomMin) ? sem_pkg::GeomMin :
                  (height_ff > sem_pkg::HeightMax) ? sem_pkg::HeightMax : height_ff;

   // ---- sequencer state ----
   sem_pkg::top_state_type state_ff, state_in;
   sem_pkg::pos_type       col_ff, col_in, row_ff, row_in;
   sem_pkg::pos_type       ccol_ff, ccol_in, crow_ff, crow_in;
   logic                   clast_ff, clast_in;
   sem_pkg::pix_type       px_ff;
   sem_pkg::pix_type       win_ff [6];
   sem_pkg::nbhd_type      nbhd_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             gray_ff;
   sem_pkg::pos_type       ocol_ff, orow_ff;
   logic                   olast_ff;

   // ---- line memory: {upper, middle} row per column, one port each way ----
   logic [47:0]            line_mem [sem_pkg::MaxWidth];
   logic [47:0]            rd_data_ff;
   logic                   rd_en, wr_en;
   sem_pkg::pix_type       top_px, mid_px;

   assign top_px = rd_data_ff[47:24];
   assign mid_px = rd_data_ff[23:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[col_ff];
      end
      if (wr_en) begin
         line_mem[col_ff] <= {mid_px, px_ff};
      end
   end

   // ---- magnitude unit ----
   sem_pkg::mag_ctl_type mag_ctl;
   sem_pkg::mag_sts_type mag_sts;

   sem_mag u_mag (
      .clock (clock),
      .reset (reset),
      .ctl   (mag_ctl),
      .nbhd  (nbhd_ff),
      .sts   (mag_sts)
   );

   // ---- handshakes ----
   logic req_beat, load_out;
   logic interior;
   logic [sem_pkg::GeomBits-1:0] col_x, row_x, col_nx, row_nx;

   assign req_bus.ready = (state_ff == sem_pkg::TOP_IDLE);
   assign req_beat      = req_bus.valid & req_bus.ready;
   assign rd_en         = req_beat;
   assign wr_en         = (state_ff == sem_pkg::TOP_READ);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.edge_gray  = gray_ff;
   assign rsp_bus.center_col = ocol_ff;
   assign rsp_bus.center_row = orow_ff;
   assign rsp_bus.frame_last = olast_ff;

   assign col_x    = {1'b0, col_ff};
   assign row_x    = {1'b0, row_ff};
   assign col_nx   = col_x + 13'd1;
   assign row_nx   = row_x + 13'd1;
   assign interior = (col_ff >= 12'd2) && (row_ff >= 12'd2) && (col_x < w_use) && (row_x < h_use);

   assign load_out = (state_ff == sem_pkg::TOP_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sem_pkg::TOP_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == sem_pkg::TOP_READ) begin
            // slide the window one column left
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_px;
            win_ff[4] <= mid_px;
            win_ff[5] <= px_ff;
         end
      end
      ccol_ff  <= ccol_in;
      crow_ff  <= crow_in;
      clast_ff <= clast_in;
      if (req_beat) begin
         px_ff <= {req_bus.red, req_bus.green, req_bus.blue};
      end
      if (state_ff == sem_pkg::TOP_READ) begin
         nbhd_ff[0] <= win_ff[0];
         nbhd_ff[1] <= win_ff[3];
         nbhd_ff[2] <= top_px;
         nbhd_ff[3] <= win_ff[1];
         nbhd_ff[4] <= win_ff[4];
         nbhd_ff[5] <= mid_px;
         nbhd_ff[6] <= win_ff[2];
         nbhd_ff[7] <= win_ff[5];
         nbhd_ff[8] <= px_ff;
      end
      if (load_out) begin
         gray_ff  <= mag_sts.gray;
         ocol_ff  <= ccol_ff;
         orow_ff  <= crow_ff;
         olast_ff <= clast_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      ccol_in       = ccol_ff;
      crow_in       = crow_ff;
      clast_in      = clast_ff;
      mag_ctl.start = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         sem_pkg::TOP_IDLE: begin
            if (req_beat) begin
               state_in = sem_pkg::TOP_READ;
            end
         end
         sem_pkg::TOP_READ: begin
            // line data for this column is in; write back and step the raster
            ccol_in  = col_ff - 12'd1;
            crow_in  = row_ff - 12'd1;
            clast_in = (col_nx == w_use) && (row_nx == h_use);
            if (col_nx >= w_use) begin
               col_in = '0;
               row_in = (row_nx >= h_use) ? '0 : row_nx[sem_pkg::ColBits-1:0];
            end else begin
               col_in = col_nx[sem_pkg::ColBits-1:0];
            end
            if (interior) begin
               state_in = sem_pkg::TOP_CALC;
            end else begin
               state_in = sem_pkg::TOP_IDLE;
            end
         end
         sem_pkg::TOP_CALC: begin
            mag_ctl.start = 1'b1;
            if (mag_sts.done) begin
               mag_ctl.start = 1'b0;
               state_in      = sem_pkg::TOP_EMIT;
            end
         end
         sem_pkg::TOP_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = sem_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = sem_pkg::TOP_IDLE;
         end
      endcase
   end

endmodule
